[hw/rtl/iil_pkg.sv]
// shared constants and types for the indexed insert list
package iil_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 16;
  localparam int VAL_W   = 32;

  typedef enum logic [1:0] {
    ST_LIST      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[hw/rtl/indexed_insert_list_core.sv]
// Ordered list of up to DEPTH signed values with insert at an index, then a full
// listing front to back and back to front. An insert at index p into a list of c
// entries moves the entries from p upward one place (S_SHIFT, S_DRAIN) and then
// writes the new one (S_PLACE, the only step when appending), then gives 2(c + 1)
// results at one per cycle while the output is not stalled; a bad index or a full
// list gives one result. All of it goes through the single read and single write
// port of the list memory, which paces it; a new request is taken once the last
// result of the previous one has left the read stage.
module indexed_insert_list_core
  import iil_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_position,
  input  logic signed [VAL_W-1:0] in_item_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic                    out_backward,
  output logic signed [VAL_W-1:0] out_entry_value,
  output logic                    out_last
);

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_DRAIN, S_PLACE, S_FWD, S_BWD} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] wptr_r, wptr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             shift_pend_r, shift_pend_nxt;

  // read stage: lines up with the memory's registered read data
  logic             rd_v_r, rd_v_nxt;
  status_t          rd_status_r, rd_status_nxt;
  logic             rd_back_r, rd_back_nxt;
  logic             rd_last_r, rd_last_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_back_r, out_back_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  mem_req_t         mreq;
  logic [VAL_W-1:0] rdata;

  logic             out_free;
  logic             can_issue;
  logic             in_acc;
  logic             bad_index;
  logic             list_full;
  logic [IDX_W-1:0] last_idx;

  iil_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign can_issue = !rd_v_r || out_free;
  assign in_stall  = !((state_r == S_IDLE) && can_issue);
  assign in_acc    = in_valid && !in_stall;
  assign bad_index = in_position[POS_W-1] ||
                     (in_position[POS_W-2:0] > (POS_W-1)'(count_r));
  assign list_full = (count_r == CNT_W'(DEPTH));
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    wptr_nxt       = wptr_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    shift_pend_nxt = shift_pend_r;
    rd_v_nxt       = out_free ? 1'b0 : rd_v_r;
    rd_status_nxt  = rd_status_r;
    rd_back_nxt    = rd_back_r;
    rd_last_nxt    = rd_last_r;
    mreq           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (bad_index || list_full) begin
            rd_v_nxt      = 1'b1;
            rd_status_nxt = bad_index ? ST_BAD_INDEX : ST_FULL;
            rd_back_nxt   = 1'b0;
            rd_last_nxt   = 1'b1;
          end else begin
            pos_nxt        = in_position[IDX_W-1:0];
            val_nxt        = in_item_value;
            shift_pend_nxt = 1'b0;
            if (in_position[CNT_W-1:0] == count_r) begin
              state_nxt = S_PLACE;
            end else begin
              ptr_nxt   = last_idx;
              state_nxt = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        // read entry ptr while writing the one read last cycle one place up
        mreq.re    = 1'b1;
        mreq.raddr = ptr_r;
        if (shift_pend_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = wptr_r;
          mreq.wdata = rdata;
        end
        wptr_nxt       = ptr_r + IDX_W'(1);
        shift_pend_nxt = 1'b1;
        if (ptr_r == pos_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
        end
      end
      S_DRAIN: begin
        mreq.we    = 1'b1;
        mreq.waddr = wptr_r;
        mreq.wdata = rdata;
        state_nxt  = S_PLACE;
      end
      S_PLACE: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_r;
        mreq.wdata = val_r;
        count_nxt  = count_r + CNT_W'(1);
        ptr_nxt    = '0;
        state_nxt  = S_FWD;
      end
      S_FWD: begin
        if (can_issue) begin
          mreq.re       = 1'b1;
          mreq.raddr    = ptr_r;
          rd_v_nxt      = 1'b1;
          rd_status_nxt = ST_LIST;
          rd_back_nxt   = 1'b0;
          rd_last_nxt   = 1'b0;
          if (ptr_r == last_idx) begin
            state_nxt = S_BWD;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
          end
        end
      end
      S_BWD: begin
        if (can_issue) begin
          mreq.re       = 1'b1;
          mreq.raddr    = ptr_r;
          rd_v_nxt      = 1'b1;
          rd_status_nxt = ST_LIST;
          rd_back_nxt   = 1'b1;
          rd_last_nxt   = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_back_nxt   = out_back_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    if (out_free) begin
      out_valid_nxt  = rd_v_r;
      out_status_nxt = rd_status_r;
      out_back_nxt   = rd_back_r;
      out_value_nxt  = (rd_status_r == ST_LIST) ? rdata : '0;
      out_last_nxt   = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    wptr_r       <= wptr_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rd_status_r  <= rd_status_nxt;
    rd_back_r    <= rd_back_nxt;
    rd_last_r    <= rd_last_nxt;
    out_status_r <= out_status_nxt;
    out_back_r   <= out_back_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      shift_pend_r <= 1'b0;
      rd_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      shift_pend_r <= shift_pend_nxt;
      rd_v_r       <= rd_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_backward    = out_back_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // error results carry no entry and close their request
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_LIST) |-> (out_entry_value == '0) && out_last)
    else $error("error result with entry value or without last");

  // an accepted request either queues an error result or starts list work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> (state_r != S_IDLE) || rd_v_r)
    else $error("accepted request left no trace");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count beyond depth");

  // the count only moves while placing the new entry
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PLACE) |=> $stable(count_r))
    else $error("list count changed outside of insert");
`endif

endmodule

[hw/rtl/iil_mem.sv]
// list storage: one write port, one read port, registered read data
module iil_mem
  import iil_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
